### rtl/smvs_pkg.sv
// Shared widths, types and field positions of the mean / variance / stddev block.
package smvs_pkg;

	// sample and set size
	localparam int SAMPLE_W    = 16;
	localparam int MAX_SAMPLES = 1024;
	localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);
	localparam int FRAC_W      = 8;

	// accumulators
	localparam int SUM_W   = SAMPLE_W + CNT_W;
	localparam int MAG_W   = SUM_W - 1;
	localparam int SQ_W    = 2 * SAMPLE_W + CNT_W - 2;
	localparam int SQ_LO_W = 21;
	localparam int SQ_HI_W = SQ_W - SQ_LO_W;

	// result fields
	localparam int MEAN_W = 24;
	localparam int VAR_W  = 38;
	localparam int SD_W   = 23;

	// shared multiplier
	localparam int MUL_W  = 26;
	localparam int PROD_W = 2 * MUL_W;
	localparam int ACC_W  = PROD_W;

	// shared divide / square root unit
	localparam int DVD_W      = ACC_W + FRAC_W;
	localparam int DEN_W      = 2 * CNT_W - 1;
	localparam int ROOT_W     = SD_W;
	localparam int REM_W      = ROOT_W + 2;
	localparam int ALU_W      = REM_W + 3;
	localparam int STEP_W     = $clog2(DVD_W + 1);
	localparam int MEAN_STEPS = MAG_W + FRAC_W;
	localparam int VAR_STEPS  = DVD_W;
	localparam int ROOT_STEPS = ROOT_W;

	// output word layout
	localparam int MEAN_LSB = 0;
	localparam int VAR_LSB  = MEAN_LSB + MEAN_W;
	localparam int SD_LSB   = VAR_LSB + VAR_W;
	localparam int CNT_LSB  = SD_LSB + SD_W;
	localparam int OUT_RAW  = CNT_LSB + CNT_W;
	localparam int OUT_W    = ((OUT_RAW + 7) / 8) * 8;
	localparam int IN_W     = ((SAMPLE_W + 7) / 8) * 8;

	typedef enum logic {
		OP_DIV,
		OP_SQRT
	} op_t;

	typedef struct packed {
		logic              start;
		op_t               op;
		logic [STEP_W-1:0] steps;
	} ds_cmd_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_ACC,
		S_SQ,
		S_MEAN,
		S_MUL1,
		S_MUL2,
		S_MUL3,
		S_MUL4,
		S_MUL5,
		S_VAR,
		S_ROOT,
		S_OUT
	} state_t;

endpackage

### rtl/smvs_divsqrt.sv
// Bit-serial restoring divider and square root sharing one subtract/compare unit.
module smvs_divsqrt import smvs_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  ds_cmd_t           cmd,
	input  logic [DVD_W-1:0]  operand,
	input  logic [DEN_W-1:0]  divisor,
	output logic              done,
	output logic [DVD_W-1:0]  quotient,
	output logic [ROOT_W-1:0] root
);

	logic              busy_q, done_q;
	op_t               op_q;
	logic [STEP_W-1:0] step_q, last_q;
	logic [DVD_W-1:0]  sh_q;
	logic [REM_W-1:0]  rem_q;
	logic [DEN_W-1:0]  den_q;
	logic [ROOT_W-1:0] root_q;

	logic [ALU_W-1:0]  alu_a, alu_b;
	logic [ALU_W:0]    diff;
	logic              fits;

	// shared subtractor: trial remainder against divisor or root trial
	always_comb begin
		if (op_q == OP_SQRT) begin
			alu_a = {{(ALU_W-REM_W-2){1'b0}}, rem_q, sh_q[DVD_W-1 -: 2]};
			alu_b = {{(ALU_W-ROOT_W-2){1'b0}}, root_q, 2'b01};
		end else begin
			alu_a = {{(ALU_W-DEN_W-1){1'b0}}, rem_q[DEN_W-1:0], sh_q[DVD_W-1]};
			alu_b = {{(ALU_W-DEN_W){1'b0}}, den_q};
		end
		diff = {1'b0, alu_a} - {1'b0, alu_b};
		fits = ~diff[ALU_W];
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			op_q   <= OP_DIV;
			step_q <= '0;
			last_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (cmd.start) begin
				busy_q <= 1'b1;
				op_q   <= cmd.op;
				step_q <= '0;
				last_q <= cmd.steps - 1'b1;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == last_q) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath: one quotient bit or one root bit per cycle
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			sh_q   <= operand;
			den_q  <= divisor;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? diff[REM_W-1:0] : alu_a[REM_W-1:0];
			if (op_q == OP_SQRT) begin
				sh_q   <= {sh_q[DVD_W-3:0], 2'b00};
				root_q <= {root_q[ROOT_W-2:0], fits};
			end else begin
				sh_q <= {sh_q[DVD_W-2:0], fits};
			end
		end
	end

	assign done     = done_q;
	assign quotient = sh_q;
	assign root     = root_q;

endmodule

### rtl/sample_mean_variance_stddev.sv
// Top level: sample accumulator, shared multiplier and result sequencer.
//
// Accumulates signed 16-bit samples and, on the word flagged by s_tlast, returns the
// population mean, variance and standard deviation in Q.8 plus the sample count, then
// clears the sums for the next set. Each ordinary sample is taken in S_IDLE and squared
// in S_ACC by the shared 26x26 multiplier (the square is added to the sum of squares
// while the next word is taken). The last sample of a set holds off the input until its
// result is in the output register: the bit-serial divide/square root unit produces
// one bit per cycle (34 for the mean, 60 for the variance, 23 for the root) and four
// multiplier passes form n*sumsq - sum^2 and n^2. A set longer than 1024 samples
// returns overflow in m_tuser with count 1024 and zero statistics. A finished result
// waits in the output register while the next set is already being accumulated.
module sample_mean_variance_stddev import smvs_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	// [15:0] sample
	input  logic [IN_W-1:0]  s_tdata,
	// last_sample
	input  logic             s_tlast,
	output logic             m_tvalid,
	input  logic             m_tready,
	// [23:0] mean_q8, [61:24] variance_q8, [84:62] stddev_q8, [95:85] sample_count
	output logic [OUT_W-1:0] m_tdata,
	// [0] overflow
	output logic             m_tuser
);

	state_t state_q, state_nx;

	logic [SAMPLE_W-1:0] sample_q;
	logic                last_q;
	logic [SUM_W-1:0]    sum_q;
	logic [SQ_W-1:0]     sumsq_q;
	logic [CNT_W-1:0]    cnt_q;
	logic                ovf_q;
	logic                pend_q;
	logic [PROD_W-1:0]   prod_q;
	logic [ACC_W-1:0]    acc_q;
	logic [MEAN_W-1:0]   mean_q;
	logic [VAR_W-1:0]    var_q;
	logic [SD_W-1:0]     sd_q;

	logic                m_tvalid_q;
	logic [OUT_W-1:0]    m_tdata_q;
	logic                m_tuser_q;

	logic                in_acc, out_free, room;
	logic [SAMPLE_W-1:0] sabs;
	logic [SUM_W-1:0]    sum_abs;
	logic [MAG_W-1:0]    mag;
	logic [MUL_W-1:0]    mul_a, mul_b;
	logic [MAG_W+FRAC_W-1:0] m_raw;
	logic [MEAN_W-1:0]   m_clip, mean_nx;
	logic [VAR_W-1:0]    var_nx;
	logic [OUT_W-1:0]    out_word;

	ds_cmd_t             ds_cmd;
	logic [DVD_W-1:0]    ds_operand;
	logic [DEN_W-1:0]    ds_divisor;
	logic                ds_done;
	logic [DVD_W-1:0]    ds_quot;
	logic [ROOT_W-1:0]   ds_root;

	assign in_acc   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;
	assign room     = cnt_q < CNT_W'(MAX_SAMPLES);

	// magnitudes of the held sample and of the running sum
	always_comb begin
		sabs    = sample_q[SAMPLE_W-1] ? (~sample_q + 1'b1) : sample_q;
		sum_abs = sum_q[SUM_W-1] ? (~sum_q + 1'b1) : sum_q;
		mag     = sum_abs[MAG_W-1:0];
	end

	// mean clamp and sign, variance saturation
	always_comb begin
		m_raw = ds_quot[MAG_W+FRAC_W-1:0];
		if (sum_q[SUM_W-1]) begin
			m_clip  = (m_raw > (MAG_W+FRAC_W)'(2 ** (MEAN_W - 1))) ?
				MEAN_W'(2 ** (MEAN_W - 1)) : m_raw[MEAN_W-1:0];
			mean_nx = ~m_clip + 1'b1;
		end else begin
			m_clip  = (m_raw > (MAG_W+FRAC_W)'(2 ** (MEAN_W - 1) - 1)) ?
				MEAN_W'(2 ** (MEAN_W - 1) - 1) : m_raw[MEAN_W-1:0];
			mean_nx = m_clip;
		end
		var_nx = (ds_quot[DVD_W-1:VAR_W] != '0) ? {VAR_W{1'b1}} : ds_quot[VAR_W-1:0];
	end

	// result word: statistics only for a set that stayed within the count limit
	always_comb begin
		out_word = '0;
		out_word[CNT_LSB +: CNT_W] = cnt_q;
		if (!ovf_q) begin
			out_word[MEAN_LSB +: MEAN_W] = mean_q;
			out_word[VAR_LSB +: VAR_W]   = var_q;
			out_word[SD_LSB +: SD_W]     = sd_q;
		end
	end

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			S_IDLE: if (in_acc) state_nx = S_ACC;
			S_ACC:  state_nx = last_q ? S_SQ : S_IDLE;
			S_SQ:   state_nx = ovf_q ? S_OUT : S_MEAN;
			S_MEAN: if (ds_done) state_nx = S_MUL1;
			S_MUL1: state_nx = S_MUL2;
			S_MUL2: state_nx = S_MUL3;
			S_MUL3: state_nx = S_MUL4;
			S_MUL4: state_nx = S_MUL5;
			S_MUL5: state_nx = S_VAR;
			S_VAR:  if (ds_done) state_nx = S_ROOT;
			S_ROOT: if (ds_done) state_nx = S_OUT;
			S_OUT:  if (out_free) state_nx = S_IDLE;
			default: state_nx = S_IDLE;
		endcase
	end

	// sequencer outputs: multiplier operands and divide / root commands
	always_comb begin
		s_tready   = 1'b0;
		mul_a      = '0;
		mul_b      = '0;
		ds_cmd     = '0;
		ds_operand = '0;
		ds_divisor = '0;
		unique case (state_q)
			S_IDLE: s_tready = 1'b1;
			S_ACC: begin
				mul_a = MUL_W'(sabs);
				mul_b = MUL_W'(sabs);
			end
			S_SQ: begin
				ds_cmd.start = !ovf_q;
				ds_cmd.op    = OP_DIV;
				ds_cmd.steps = STEP_W'(MEAN_STEPS);
				ds_operand   = {mag, {FRAC_W{1'b0}}, {(DVD_W-MEAN_STEPS){1'b0}}};
				ds_divisor   = DEN_W'(cnt_q);
			end
			S_MUL1: begin
				mul_a = MUL_W'(cnt_q);
				mul_b = MUL_W'(sumsq_q[SQ_LO_W-1:0]);
			end
			S_MUL2: begin
				mul_a = MUL_W'(cnt_q);
				mul_b = MUL_W'(sumsq_q[SQ_W-1:SQ_LO_W]);
			end
			S_MUL3: begin
				mul_a = MUL_W'(mag);
				mul_b = MUL_W'(mag);
			end
			S_MUL4: begin
				mul_a = MUL_W'(cnt_q);
				mul_b = MUL_W'(cnt_q);
			end
			S_MUL5: begin
				ds_cmd.start = 1'b1;
				ds_cmd.op    = OP_DIV;
				ds_cmd.steps = STEP_W'(VAR_STEPS);
				ds_operand   = {acc_q, {FRAC_W{1'b0}}};
				ds_divisor   = prod_q[DEN_W-1:0];
			end
			S_VAR: begin
				ds_cmd.start = ds_done;
				ds_cmd.op    = OP_SQRT;
				ds_cmd.steps = STEP_W'(ROOT_STEPS);
				ds_operand   = {var_nx, {FRAC_W{1'b0}}, {(DVD_W-VAR_W-FRAC_W){1'b0}}};
			end
			S_MEAN, S_ROOT, S_OUT: ;
			default: ;
		endcase
	end

	// state and accumulator control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			sum_q      <= '0;
			sumsq_q    <= '0;
			cnt_q      <= '0;
			ovf_q      <= 1'b0;
			pend_q     <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			// square of the previous sample is added to the sum of squares in the cycle after its multiply
			if (pend_q) begin
				sumsq_q <= sumsq_q + SQ_W'(prod_q);
				pend_q  <= 1'b0;
			end
			if (state_q == S_ACC) begin
				if (room) begin
					sum_q  <= sum_q + {{(SUM_W-SAMPLE_W){sample_q[SAMPLE_W-1]}}, sample_q};
					cnt_q  <= cnt_q + 1'b1;
					pend_q <= 1'b1;
				end else begin
					ovf_q <= 1'b1;
				end
			end
			if (state_q == S_OUT && out_free) begin
				m_tvalid_q <= 1'b1;
				sum_q      <= '0;
				sumsq_q    <= '0;
				cnt_q      <= '0;
				ovf_q      <= 1'b0;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		if (in_acc) begin
			sample_q <= s_tdata[SAMPLE_W-1:0];
			last_q   <= s_tlast;
		end
		case (state_q)
			S_MEAN: if (ds_done) mean_q <= mean_nx;
			S_MUL2: acc_q <= prod_q;
			S_MUL3: acc_q <= acc_q + {prod_q[ACC_W-SQ_LO_W-1:0], {SQ_LO_W{1'b0}}};
			S_MUL4: acc_q <= acc_q - prod_q;
			S_VAR:  if (ds_done) var_q <= var_nx;
			S_ROOT: if (ds_done) sd_q <= ds_root;
			default: ;
		endcase
		if (state_q == S_OUT && out_free) begin
			m_tdata_q <= out_word;
			m_tuser_q <= ovf_q;
		end
	end

	smvs_divsqrt u_divsqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (ds_cmd),
		.operand  (ds_operand),
		.divisor  (ds_divisor),
		.done     (ds_done),
		.quotient (ds_quot),
		.root     (ds_root)
	);

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule

### rtl/smvs_checker.sv
// Port-level checks of the statistics block, bound to the top level.
module smvs_checker import smvs_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             s_tvalid,
	input logic             s_tready,
	input logic [IN_W-1:0]  s_tdata,
	input logic             s_tlast,
	input logic             m_tvalid,
	input logic             m_tready,
	input logic [OUT_W-1:0] m_tdata,
	input logic             m_tuser
);

	// the block is busy the cycle after it takes a word
	a_busy_after_word: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("input ready right after a word was taken");

	// an ordinary sample frees the input again once its S_ACC state is over
	a_sample_rate: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && !s_tlast) |-> ##2 s_tready)
		else $error("input not ready two cycles after an ordinary sample");

	// an overflowed set reports a full count and no statistics
	a_overflow_word: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |->
		(m_tdata[CNT_LSB +: CNT_W] == CNT_W'(MAX_SAMPLES)) && (m_tdata[CNT_LSB-1:0] == '0))
		else $error("overflow result carries statistics or a short count");

	// every result counts at least one sample
	a_count_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[CNT_LSB +: CNT_W] != '0))
		else $error("result with zero sample count");

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
		else $error("result changed while stalled");

endmodule

bind sample_mean_variance_stddev smvs_checker u_checker (.*);
